FILE: design/bb_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur.
`default_nettype none
package bb_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH       = 4;
   localparam int RECIP_SHIFT       = 18;
   localparam int PIXEL_BITS        = 24;

   localparam logic [0:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_TAIL  = 2'd1,
      OP_DRAIN = 2'd2
   } bb_kind_type;

   // One unit of work for the back end; px is {red, green, blue}.
   typedef struct packed {
      bb_kind_type             kind;
      logic [PIXEL_BITS-1:0]   px;
      logic                    emit;
      logic [2:0]              colmask;
      logic [2:0]              rowmask;
      logic                    capture;
      logic                    last;
   } bb_op_type;

   // Number of pixels summed for a given column and row count.
   function automatic logic [3:0] bb_count(input logic [1:0] ncol, input logic [1:0] nrow);
      return 4'({2'b00, ncol} * {2'b00, nrow});
   endfunction

   // Reciprocal of twice the pixel count, scaled by 2^RECIP_SHIFT and rounded up.
   function automatic logic [17:0] bb_recip(input logic [3:0] n);
      logic [17:0] m;
      case (n)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd6:    m = 18'd21846;
         4'd9:    m = 18'd14564;
         default: m = 18'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: design/box_blur_3x3.sv
// Top level of the streaming 3x3 box blur over RGB raster pixels.
//
//  Channel  Ports                         Direction  Beat contents
//  req      req_tvalid/tready/tdata/tuser in         tdata: red, green, blue; tuser: cmd
//  rsp      rsp_tvalid/tready/tdata/tlast out        tdata: red, green, blue; tlast: frame_end
//  csr      csr_wen/csr_index/csr_wdata   in         0 = image_width, 1 = image_height
//
// One request beat is taken every cycle while the queue has room; a pixel at the last column
// of any row but the first holds the next beat back while its row-end item is pushed, since
// it yields two results, which leave the back end one per cycle unless the output stalls.
// A result passes the queue, the line store read and the neighborhood sum, and the reciprocal
// multiply feeds the output register. Reset is synchronous and active high; it restores a
// 640 by 480 frame and empties the pipeline. The line store holds no reset state, since no
// unwritten column reaches a result. A stalled result holds the whole back end; the
// four-entry queue keeps the front taking beats until it fills.
`default_nettype none
module box_blur_3x3 #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
   input  wire logic [0:0]  req_tuser,   // [0] cmd: 0 pixel, 1 drain
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic             rsp_tlast    // frame_end
);
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int OW = $bits(bb_pkg::bb_op_type);

   logic              f_push, q_full, q_valid, q_pop;
   bb_pkg::bb_op_type f_op, q_op;
   logic [CW-1:0]     f_addr, q_addr;
   logic [CW+OW-1:0]  q_out;

   // The front end classifies each beat and tracks the raster position.
   bb_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_push    (f_push),
      .op_data    (f_op),
      .op_addr    (f_addr),
      .op_full    (q_full)
   );

   // Work items wait here so the front keeps taking beats while the output stalls.
   bb_fifo #(.WIDTH(CW + OW), .DEPTH(bb_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_addr, f_op}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   assign q_op   = bb_pkg::bb_op_type'(q_out[OW-1:0]);
   assign q_addr = q_out[CW+OW-1:OW];

   // The back end owns the line store, both windows and the averaging pipeline.
   bb_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (q_valid),
      .op_data    (q_op),
      .op_addr    (q_addr),
      .op_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: design/bb_fifo.sv
// Small register queue that carries work items from the front end to the back end.
`default_nettype none
module bb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bb_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full     = (count_ff == NW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/bb_front.sv
// Front end: configuration, position counters and splitting of beats into work items.
`default_nettype none
module bb_front #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEFAULT,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire logic [0:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,
   input  wire logic [0:0]           req_tuser,
   output logic                      op_push,
   output bb_pkg::bb_op_type         op_data,
   output logic [CW-1:0]             op_addr,
   input  wire logic                 op_full
);
   function automatic logic [CW-1:0] f_wlast(input logic [10:0] v);
      logic [10:0] m1;
      m1 = v - 11'd1;
      if (v == 11'd0) begin
         return '0;
      end else if (32'(v) > MAX_WIDTH) begin
         return CW'(MAX_WIDTH - 1);
      end else begin
         return CW'(m1);
      end
   endfunction

   logic [CW-1:0] wlast_ff, wlast_in;
   logic [15:0]   height_ff, height_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [15:0]   in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic          tail_pend_ff, tail_pend_in;
   logic          tail_top_ff, tail_top_in;

   logic            accept, is_drain, pix_ok, drn_ok, emit_a, emit_b;
   logic [CW-1:0]   out_col_next;
   bb_pkg::bb_op_type pix_op, drn_op, tail_op;

   assign req_tready = !tail_pend_ff && !op_full;
   assign accept     = req_tvalid && req_tready;
   assign is_drain   = (req_tuser[0] == bb_pkg::CMD_DRAIN);
   assign pix_ok     = (in_row_ff < height_ff);
   assign drn_ok     = !pix_ok && (out_col_ff <= wlast_ff);
   assign emit_a     = (in_row_ff != 16'd0) && (in_col_ff != '0);
   assign emit_b     = (in_row_ff != 16'd0) && (in_col_ff == wlast_ff);
   assign out_col_next = (out_col_ff == wlast_ff) ? '0 : out_col_ff + CW'(1);

   always_comb begin
      // Pixel beats arrive as {blue, green, red} and travel as {red, green, blue}.
      pix_op.kind    = bb_pkg::OP_PIXEL;
      pix_op.px      = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      pix_op.emit    = emit_a;
      pix_op.colmask = {1'b1, 1'b1, (in_col_ff > CW'(1))};
      pix_op.rowmask = {1'b1, 1'b1, (in_row_ff > 16'd1)};
      pix_op.capture = (in_row_ff == height_ff - 16'd1) && (in_col_ff == '0);
      pix_op.last    = 1'b0;

      drn_op.kind    = bb_pkg::OP_DRAIN;
      drn_op.px      = '0;
      drn_op.emit    = 1'b1;
      drn_op.colmask = {(out_col_ff != wlast_ff), 1'b1, (out_col_ff != '0)};
      drn_op.rowmask = {1'b1, (height_ff > 16'd1), 1'b0};
      drn_op.capture = 1'b0;
      drn_op.last    = (out_col_ff == wlast_ff);

      tail_op.kind    = bb_pkg::OP_TAIL;
      tail_op.px      = '0;
      tail_op.emit    = 1'b1;
      tail_op.colmask = {1'b1, (wlast_ff != '0), 1'b0};
      tail_op.rowmask = {1'b1, 1'b1, tail_top_ff};
      tail_op.capture = 1'b0;
      tail_op.last    = 1'b0;
   end

   always_comb begin
      wlast_in     = wlast_ff;
      height_in    = height_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      tail_pend_in = tail_pend_ff;
      tail_top_in  = tail_top_ff;
      op_push      = 1'b0;
      op_data      = pix_op;
      op_addr      = in_col_ff;

      if (csr_wen) begin
         case (csr_index)
            bb_pkg::CSR_IMAGE_WIDTH:  wlast_in  = f_wlast(csr_wdata[10:0]);
            bb_pkg::CSR_IMAGE_HEIGHT: height_in = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
            default:                  wlast_in  = wlast_ff;
         endcase
         in_col_in    = '0;
         in_row_in    = '0;
         out_col_in   = '0;
         tail_pend_in = 1'b0;
      end else if (tail_pend_ff) begin
         op_data = tail_op;
         if (!op_full) begin
            op_push      = 1'b1;
            tail_pend_in = 1'b0;
            out_col_in   = out_col_next;
         end
      end else if (accept) begin
         if (is_drain) begin
            if (drn_ok) begin
               op_push = 1'b1;
               op_data = drn_op;
               op_addr = out_col_ff + CW'(1);
               if (drn_op.last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
               end else begin
                  out_col_in = out_col_next;
               end
            end
         end else if (pix_ok) begin
            op_push      = 1'b1;
            tail_pend_in = emit_b;
            tail_top_in  = (in_row_ff > 16'd1);
            if (emit_a) begin
               out_col_in = out_col_next;
            end
            if (in_col_ff == wlast_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 16'd1;
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff     <= f_wlast(11'd640);
         height_ff    <= 16'd480;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         tail_pend_ff <= 1'b0;
         tail_top_ff  <= 1'b0;
      end else begin
         wlast_ff     <= wlast_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         tail_pend_ff <= tail_pend_in;
         tail_top_ff  <= tail_top_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/bb_back.sv
// Back end: line store, sliding windows, neighborhood sums and rounded means.
`default_nettype none
module bb_back #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEFAULT,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   input  wire bb_pkg::bb_op_type op_data,
   input  wire logic [CW-1:0]     op_addr,
   output logic                   op_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   localparam int PB = bb_pkg::PIXEL_BITS;

   // Each entry holds the two previous rows of one column: {older, newer}.
   logic [2*PB-1:0] line_mem [MAX_WIDTH];

   logic              move;
   logic              b1_valid_ff;
   bb_pkg::bb_op_type b1_op_ff;
   logic [CW-1:0]     b1_addr_ff;
   logic [2*PB-1:0]   rdata_ff;
   logic              mem_wr;
   logic [2*PB-1:0]   mem_wdata;

   logic [2:0][2:0][PB-1:0] win_ff, win_in;
   logic [1:0][1:0][PB-1:0] dwin_ff, dwin_in;
   logic [2:0][2:0][PB-1:0] cand;

   logic [11:0] sum_r, sum_g, sum_b;
   logic [1:0]  ncol, nrow;

   logic        b2_valid_ff;
   logic [11:0] b2_sum_ff [3];
   logic [1:0]  b2_ncol_ff, b2_nrow_ff;
   logic        b2_last_ff;

   logic [3:0]  cnt;
   logic [17:0] recip;
   logic [30:0] prod [3];

   logic        out_valid_ff;
   logic [23:0] out_data_ff;
   logic        out_last_ff;

   logic [PB-1:0] ra, rb;

   assign move   = !out_valid_ff || rsp_tready;
   assign op_pop = move && op_valid;
   assign ra     = rdata_ff[2*PB-1:PB];
   assign rb     = rdata_ff[PB-1:0];
   assign mem_wr    = move && b1_valid_ff && (b1_op_ff.kind == bb_pkg::OP_PIXEL);
   assign mem_wdata = {rb, b1_op_ff.px};

   // Line store with write-first forwarding for a read of the column being written.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[b1_addr_ff] <= mem_wdata;
      end
      if (op_pop) begin
         if (mem_wr && (b1_addr_ff == op_addr)) begin
            rdata_ff <= mem_wdata;
         end else begin
            rdata_ff <= line_mem[op_addr];
         end
         b1_op_ff   <= op_data;
         b1_addr_ff <= op_addr;
      end
   end

   always_comb begin
      win_in  = win_ff;
      dwin_in = dwin_ff;
      cand    = win_ff;
      case (b1_op_ff.kind)
         bb_pkg::OP_PIXEL: begin
            cand[0] = win_ff[1];
            cand[1] = win_ff[2];
            cand[2] = {b1_op_ff.px, rb, ra};
            win_in  = cand;
            if (b1_op_ff.capture) begin
               dwin_in[1] = {b1_op_ff.px, rb};
            end
         end
         bb_pkg::OP_TAIL: begin
            cand = win_ff;
         end
         bb_pkg::OP_DRAIN: begin
            // Rows of the drain window: index 0 is the older row, 1 the last row.
            cand[0] = {dwin_ff[0][1], dwin_ff[0][0], {PB{1'b0}}};
            cand[1] = {dwin_ff[1][1], dwin_ff[1][0], {PB{1'b0}}};
            cand[2] = {rb, ra, {PB{1'b0}}};
            dwin_in[0] = dwin_ff[1];
            dwin_in[1] = {rb, ra};
         end
         default: begin
            cand = win_ff;
         end
      endcase
   end

   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (b1_op_ff.colmask[i] && b1_op_ff.rowmask[j]) begin
               sum_r = sum_r + 12'(cand[i][j][23:16]);
               sum_g = sum_g + 12'(cand[i][j][15:8]);
               sum_b = sum_b + 12'(cand[i][j][7:0]);
            end
         end
      end
      ncol = 2'($countones(b1_op_ff.colmask));
      nrow = 2'($countones(b1_op_ff.rowmask));
   end

   always_ff @(posedge clock) begin
      if (move && b1_valid_ff) begin
         win_ff        <= win_in;
         dwin_ff       <= dwin_in;
         b2_sum_ff[0]  <= sum_r;
         b2_sum_ff[1]  <= sum_g;
         b2_sum_ff[2]  <= sum_b;
         b2_ncol_ff    <= ncol;
         b2_nrow_ff    <= nrow;
         b2_last_ff    <= b1_op_ff.last;
      end
   end

   // Rounded mean: floor((2*sum + n) / (2*n)) through a scaled reciprocal.
   always_comb begin
      cnt   = bb_pkg::bb_count(b2_ncol_ff, b2_nrow_ff);
      recip = bb_pkg::bb_recip(cnt);
      for (int k = 0; k < 3; k++) begin
         prod[k] = {18'd0, {b2_sum_ff[k], 1'b0} + 13'(cnt)} * {13'd0, recip};
      end
   end

   always_ff @(posedge clock) begin
      if (move && b2_valid_ff) begin
         out_data_ff <= {prod[2][bb_pkg::RECIP_SHIFT+7:bb_pkg::RECIP_SHIFT],
                         prod[1][bb_pkg::RECIP_SHIFT+7:bb_pkg::RECIP_SHIFT],
                         prod[0][bb_pkg::RECIP_SHIFT+7:bb_pkg::RECIP_SHIFT]};
         out_last_ff <= b2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (move) begin
         b1_valid_ff  <= op_valid;
         b2_valid_ff  <= b1_valid_ff && b1_op_ff.emit;
         out_valid_ff <= b2_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      b2_valid_ff |-> (b2_ncol_ff != 2'd0) && (b2_nrow_ff != 2'd0))
      else $error("mean stage holds a result with an empty neighborhood");

   a_stall_holds_sums: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(b2_sum_ff[0]) && $stable(b2_valid_ff))
      else $error("sum stage moved while the output was stalled");

   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> b1_valid_ff && move)
      else $error("line store written without a pixel item advancing");

   a_tail_emits: assert property (@(posedge clock) disable iff (reset)
      (b1_valid_ff && (b1_op_ff.kind == bb_pkg::OP_TAIL || b1_op_ff.kind == bb_pkg::OP_DRAIN))
      |-> b1_op_ff.emit)
      else $error("row-end or drain item without a result");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking stream testbench of the 3x3 box blur, with its own pixel predictor.
`timescale 1ns / 100ps
module tb;

   localparam int LINE_MAX = 1024;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct {
      logic    cmd;
      rgb_type px;
   } req_beat_type;

   typedef struct {
      rgb_type px;
      logic    frame_end;
   } blur_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [0:0]  csr_index = bb_pkg::CSR_IMAGE_WIDTH;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
   logic [0:0]  req_tuser = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   logic        rsp_tlast;

   // Beats waiting to be driven, and blurred pixels waiting to come out.
   req_beat_type    pending_beats[$];
   blur_result_type blurred_pixels[$];

   int  mismatch_count = 0;
   bit  presenting = 0;
   bit  calm = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   int  beats_made = 0;

   // Predictor state: the image size, the two previous rows, the 3x3 window
   // (indexed [column][row], newest last) and the input and output positions.
   logic [10:0] blur_width;
   logic [15:0] blur_height;
   rgb_type     row_older[LINE_MAX];
   rgb_type     row_newer[LINE_MAX];
   rgb_type     win[3][3];
   int          in_col, in_line, out_col, out_line;

   box_blur_3x3 i_dut (
      .clock, .reset, .csr_wen, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   always #4 clock = ~clock;

   function automatic int width_used();
      if (blur_width == 0) return 1;
      if (blur_width > LINE_MAX) return LINE_MAX;
      return blur_width;
   endfunction

   function automatic int height_used();
      return (blur_height == 0) ? 1 : blur_height;
   endfunction

   function automatic void restart_frame();
      in_col = 0;
      in_line = 0;
      out_col = 0;
      out_line = 0;
   endfunction

   function automatic void blur_config(logic [0:0] idx, logic [15:0] val);
      if (idx == bb_pkg::CSR_IMAGE_WIDTH) begin
         blur_width = val[10:0];
      end else begin
         blur_height = val;
      end
      restart_frame();
   endfunction

   // Adds one pixel to the per-channel sums.
   function automatic void accumulate(rgb_type p, ref int s[3], ref int n);
      s[0] += p.red;
      s[1] += p.green;
      s[2] += p.blue;
      n++;
   endfunction

   // Rounded mean, half up, of each channel; queued as the next expected pixel.
   function automatic void push_mean(int s[3], int n, logic fend);
      blur_result_type res;
      res.px.red   = 8'((2 * s[0] + n) / (2 * n));
      res.px.green = 8'((2 * s[1] + n) / (2 * n));
      res.px.blue  = 8'((2 * s[2] + n) / (2 * n));
      res.frame_end = fend;
      blurred_pixels.push_back(res);
   endfunction

   function automatic void advance_out(int w);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_line = (out_line + 1) & 16'hFFFF;
      end
   endfunction

   function automatic void window_mean(int first, bit top_ok);
      int s[3];
      int n;
      s = '{0, 0, 0};
      n = 0;
      for (int c = first; c < 3; c++) begin
         if (top_ok) accumulate(win[c][0], s, n);
         accumulate(win[c][1], s, n);
         accumulate(win[c][2], s, n);
      end
      push_mean(s, n, 1'b0);
   endfunction

   // Works out the blurred pixels that one accepted beat produces.
   function automatic void blur_step(req_beat_type b);
      int w, h, lo, hi, n;
      int s[3];
      bit fend;
      w = width_used();
      h = height_used();
      if (b.cmd == bb_pkg::CMD_DRAIN) begin
         // A drain only produces once the last row is in and not yet drained.
         if (in_line < h || out_col >= w) return;
         s = '{0, 0, 0};
         n = 0;
         lo = (out_col == 0) ? 0 : out_col - 1;
         hi = (out_col + 1 < w) ? out_col + 1 : out_col;
         for (int x = lo; x <= hi; x++) begin
            if (h >= 2) accumulate(row_older[x], s, n);
            accumulate(row_newer[x], s, n);
         end
         fend = (out_col == w - 1);
         push_mean(s, n, fend);
         if (fend) restart_frame();
         else advance_out(w);
         return;
      end
      // Pixels past the last row are dropped until the frame is drained.
      if (in_line >= h || in_col >= w) return;
      for (int c = 0; c < 2; c++)
         for (int r = 0; r < 3; r++) win[c][r] = win[c + 1][r];
      win[2][0] = row_older[in_col];
      win[2][1] = row_newer[in_col];
      win[2][2] = b.px;
      row_older[in_col] = row_newer[in_col];
      row_newer[in_col] = b.px;
      if (in_line >= 1) begin
         if (in_col >= 1) begin
            window_mean(in_col >= 2 ? 0 : 1, in_line >= 2);
            advance_out(w);
         end
         if (in_col == w - 1) begin
            window_mean(w >= 2 ? 1 : 2, in_line >= 2);
            advance_out(w);
         end
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_line++;
      end
   endfunction

   // Sampling side: request acceptance feeds the predictor, result beats are checked.
   always @(posedge clock) begin
      blur_result_type want;
      if (!reset && req_tvalid && req_tready) begin
         blur_step(pending_beats[0]);
         void'(pending_beats.pop_front());
         presenting = 0;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blurred_pixels.size() == 0) begin
            $display("%0t: unexpected result beat %h last %b", $time, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = blurred_pixels.pop_front();
            if (rsp_tdata !== {want.px.blue, want.px.green, want.px.red}
                || rsp_tlast !== want.frame_end) begin
               $display("%0t: expected %h last %b, got %h last %b", $time,
                        {want.px.blue, want.px.green, want.px.red}, want.frame_end,
                        rsp_tdata, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Driving side: request beats and result back-pressure change at the falling edge,
   // with random bursts of idle cycles until the final calm stretch.
   always @(negedge clock) begin
      if (!reset) begin
         if (!presenting) begin
            if (send_gap == 0 && !calm && $urandom_range(0, 11) == 0)
               send_gap = $urandom_range(1, 9);
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               presenting = 1;
               req_tvalid <= 1'b1;
               req_tuser  <= pending_beats[0].cmd;
               req_tdata  <= {pending_beats[0].px.blue, pending_beats[0].px.green,
                              pending_beats[0].px.red};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (recv_stall == 0 && !calm && $urandom_range(0, 11) == 0)
            recv_stall = $urandom_range(1, 9);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] channel_value();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void queue_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] bl);
      req_beat_type b;
      b.cmd = cmd;
      b.px.red = r;
      b.px.green = g;
      b.px.blue = bl;
      pending_beats.push_back(b);
      beats_made++;
   endfunction

   function automatic void queue_pixel();
      queue_beat(bb_pkg::CMD_PIXEL, channel_value(), channel_value(), channel_value());
   endfunction

   function automatic void queue_drain();
      queue_beat(bb_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // A frame of w by h pixels; a partial frame stops after the given number of pixels.
   // Noise adds stray drains mid-frame, pixels after the last row and extra drains.
   function automatic void queue_frame(int w, int h, int pixels, bit noise);
      for (int i = 0; i < pixels; i++) begin
         if (noise && $urandom_range(0, 15) == 0) queue_drain();
         queue_pixel();
      end
      if (pixels < w * h) return;
      if (noise) repeat ($urandom_range(0, 2)) queue_pixel();
      for (int i = 0; i < w; i++) queue_drain();
      if (noise) repeat ($urandom_range(0, 2)) queue_beat(bb_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
   endfunction

   // Waits until the block is idle, then writes one register.
   task automatic csr_write(logic [0:0] idx, logic [15:0] val);
      wait (pending_beats.size() == 0 && !presenting && blurred_pixels.size() == 0);
      repeat (10) @(posedge clock);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      blur_config(idx, val);
   endtask

   task automatic set_size(logic [15:0] w, logic [15:0] h);
      csr_write(bb_pkg::CSR_IMAGE_WIDTH, w);
      csr_write(bb_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   initial begin
      int w, h, wr, hr;
      bit wide_done;
      wide_done = 0;
      blur_width  = 11'd640;
      blur_height = 16'd480;
      for (int i = 0; i < LINE_MAX; i++) begin
         row_older[i] = '{8'h00, 8'h00, 8'h00};
         row_newer[i] = '{8'h00, 8'h00, 8'h00};
      end
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++) win[c][r] = '{8'h00, 8'h00, 8'h00};
      restart_frame();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The reset size takes a few pixels of row zero and an early drain.
      queue_frame(640, 480, 6, 0);
      queue_beat(bb_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      // A 3x3 frame of all white followed by black, edges and corners at both extremes.
      set_size(16'd3, 16'd3);
      for (int i = 0; i < 9; i++)
         queue_beat(bb_pkg::CMD_PIXEL, (i < 5) ? 8'hFF : 8'h00, (i < 5) ? 8'hFF : 8'h00,
                    (i < 5) ? 8'hFF : 8'h00);
      repeat (4) queue_beat(bb_pkg::CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      // Zero width and height fall back to one; upper bits of the width write are dropped.
      set_size(16'hF800, 16'd0);
      queue_pixel();
      queue_pixel();
      queue_beat(bb_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      queue_beat(bb_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
      // A single column of the tallest image, left partway through.
      set_size(16'd1, 16'hFFFF);
      repeat (4) queue_pixel();

      // Random frames, mostly small and well formed, with the first row and a few pixels
      // of the next one of a frame at the widest size.
      while (beats_made < 1550) begin
         if (beats_made > 1300) calm = 1;
         wr = $urandom_range(0, 19);
         if (wr == 0) w = 0;
         else if (wr == 1) w = $urandom_range(13, 40);
         else w = $urandom_range(1, 12);
         hr = $urandom_range(0, 19);
         h = (hr == 0) ? 0 : (hr == 1) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         set_size(16'(w) | 16'($urandom_range(0, 31) << 11), 16'(h));
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         if ($urandom_range(0, 9) == 0) queue_frame(w, h, $urandom_range(0, w * h), 1);
         else queue_frame(w, h, w * h, $urandom_range(0, 1));
         if (!wide_done && beats_made > 300) begin
            set_size(16'd2047, 16'd2);
            queue_frame(LINE_MAX, 2, LINE_MAX + 3, 0);
            wide_done = 1;
         end
      end

      wait (pending_beats.size() == 0 && !presenting && blurred_pixels.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && blurred_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule
